// ===== design/bounded_deque_top_assert.svh =====
// ----------------------------------------------------------------------------
// bounded_deque_top assertion macros
// Concurrent assertion wrappers used by the deque controller; empty in synthesis.
// ----------------------------------------------------------------------------
`ifndef BOUNDED_DEQUE_TOP_ASSERT_SVH
`define BOUNDED_DEQUE_TOP_ASSERT_SVH

`ifndef SYNTH

// Check a property on every clock edge outside reset
`define BDQ_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check a property on every clock edge, reset included
`define BDQ_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`else

`define BDQ_ASSERT(lbl, clk, rst_n, prop, msg)
`define BDQ_ASSERT_ALWAYS(lbl, clk, prop, msg)

`endif

`endif

// ===== design/bdq_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bdq_pkg
// Types, codes and ring index helpers for the bounded double-ended queue.
// ----------------------------------------------------------------------------
package bdq_pkg;

    localparam int DEPTH  = 16;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int SUM_W  = CNT_W + 1;
    localparam int DATA_W = 32;

    typedef enum logic [2:0] {
        OP_PUSH_FRONT = 3'd0,
        OP_PUSH_BACK  = 3'd1,
        OP_POP_FRONT  = 3'd2,
        OP_POP_BACK   = 3'd3,
        OP_DUMP       = 3'd4
    } t_op;

    typedef enum logic [1:0] {
        ST_ACCEPTED = 2'd0,
        ST_ELEMENT  = 2'd1,
        ST_EMPTY    = 2'd2,
        ST_FULL     = 2'd3
    } t_status;

    typedef enum logic {
        S_IDLE,
        S_EMIT
    } t_state;

    typedef struct packed {
        logic [2:0]               operation;
        logic signed [DATA_W-1:0] value;
    } t_in_word;

    typedef struct packed {
        logic signed [DATA_W-1:0] value_res;
        t_status                  status;
        logic                     last;
    } t_out_word;

    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] waddr;
        logic [DATA_W-1:0] wdata;
        logic              re;
        logic [ADDR_W-1:0] raddr;
    } t_ram_req;

    // Ring position base + off, with off no larger than DEPTH
    function automatic logic [ADDR_W-1:0] ring_add(
        input logic [ADDR_W-1:0] base,
        input logic [CNT_W-1:0]  off
    );
        logic [SUM_W-1:0] sum;
        sum = SUM_W'(base) + SUM_W'(off);
        if (sum >= SUM_W'(DEPTH)) begin
            sum = sum - SUM_W'(DEPTH);
        end
        return sum[ADDR_W-1:0];
    endfunction

    function automatic logic [ADDR_W-1:0] ring_inc(input logic [ADDR_W-1:0] base);
        return (base == ADDR_W'(DEPTH - 1)) ? '0 : base + ADDR_W'(1);
    endfunction

    function automatic logic [ADDR_W-1:0] ring_dec(input logic [ADDR_W-1:0] base);
        return (base == '0) ? ADDR_W'(DEPTH - 1) : base - ADDR_W'(1);
    endfunction

endpackage

// ===== design/bdq_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bdq_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module bdq_ram #(
    parameter int W = 32,
    parameter int D = 16
) (
    input  logic                 i_clk,
    input  logic                 i_we,
    input  logic [$clog2(D)-1:0] i_waddr,
    input  logic [W-1:0]         i_wdata,
    input  logic                 i_re,
    input  logic [$clog2(D)-1:0] i_raddr,
    output logic [W-1:0]         o_rdata
);

    logic [W-1:0] r_mem [D];
    logic [W-1:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Read port, data held until the next read
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== design/bdq_obuf.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bdq_obuf
// Output word register between the deque controller and the result channel.
// ----------------------------------------------------------------------------
module bdq_obuf (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_load,
    input  bdq_pkg::t_out_word i_word,
    output logic              o_ready,
    output logic              o_valid,
    input  logic              i_stall,
    output bdq_pkg::t_out_word o_word
);
    import bdq_pkg::*;

    logic      r_valid;
    t_out_word r_word;

    // Free when empty or when the held word leaves this cycle
    assign o_ready = !r_valid || !i_stall;

    // Track occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (!i_stall) begin
            r_valid <= 1'b0;
        end
    end

    // Capture the new word
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_word <= i_word;
        end
    end

    assign o_valid = r_valid;
    assign o_word  = r_word;

endmodule

// ===== design/bdq_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bdq_ctrl
// Deque controller: front index, count, RAM access and dump sequencing.
// ----------------------------------------------------------------------------
`include "bounded_deque_top_assert.svh"

module bdq_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  bdq_pkg::t_in_word  i_in_word,
    output logic               o_in_stall,
    input  logic               i_out_ready,
    output logic               o_load,
    output bdq_pkg::t_out_word o_word,
    output bdq_pkg::t_ram_req  o_ram,
    input  logic [bdq_pkg::DATA_W-1:0] i_rdata
);
    import bdq_pkg::*;

    t_state            r_state, n_state;
    logic [ADDR_W-1:0] r_front, n_front;
    logic [CNT_W-1:0]  r_count, n_count;
    logic [ADDR_W-1:0] r_addr, n_addr;
    logic [ADDR_W-1:0] r_left, n_left;
    logic              accept;
    logic              full;
    logic              empty;
    logic [CNT_W-1:0]  count_m1;

    assign full     = (r_count == CNT_W'(DEPTH));
    assign empty    = (r_count == '0);
    assign count_m1 = r_count - CNT_W'(1);

    // Take a word only when idle and the output register can take its result
    assign o_in_stall = !((r_state == S_IDLE) && i_out_ready);
    assign accept     = i_in_valid && !o_in_stall;

    // Next state, RAM requests and results
    always_comb begin
        n_state       = r_state;
        n_front       = r_front;
        n_count       = r_count;
        n_addr        = r_addr;
        n_left        = r_left;
        o_load        = 1'b0;
        o_word        = '{value_res: '0, status: ST_ACCEPTED, last: 1'b1};
        o_ram         = '0;
        o_ram.wdata   = i_in_word.value;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    case (t_op'(i_in_word.operation))
                        OP_PUSH_FRONT, OP_PUSH_BACK: begin
                            o_load = 1'b1;
                            if (full) begin
                                o_word.status = ST_FULL;
                            end else begin
                                o_ram.we = 1'b1;
                                n_count  = r_count + CNT_W'(1);
                                if (t_op'(i_in_word.operation) == OP_PUSH_FRONT) begin
                                    n_front     = ring_dec(r_front);
                                    o_ram.waddr = ring_dec(r_front);
                                end else begin
                                    o_ram.waddr = ring_add(r_front, r_count);
                                end
                            end
                        end
                        OP_POP_FRONT, OP_POP_BACK, OP_DUMP: begin
                            if (empty) begin
                                o_load        = 1'b1;
                                o_word.status = ST_EMPTY;
                            end else begin
                                o_ram.re = 1'b1;
                                n_state  = S_EMIT;
                                n_left   = '0;
                                case (t_op'(i_in_word.operation))
                                    OP_POP_FRONT: begin
                                        o_ram.raddr = r_front;
                                        n_front     = ring_inc(r_front);
                                        n_count     = count_m1;
                                    end
                                    OP_POP_BACK: begin
                                        o_ram.raddr = ring_add(r_front, count_m1);
                                        n_count     = count_m1;
                                    end
                                    default: begin
                                        o_ram.raddr = r_front;
                                        n_addr      = r_front;
                                        n_left      = count_m1[ADDR_W-1:0];
                                    end
                                endcase
                            end
                        end
                        default: begin
                            // unused codes: drop silently
                        end
                    endcase
                end
            end
            S_EMIT: begin
                // Emit the element the RAM read last; read the next one if any
                if (i_out_ready) begin
                    o_load           = 1'b1;
                    o_word.value_res = i_rdata;
                    o_word.status    = ST_ELEMENT;
                    o_word.last      = (r_left == '0);
                    if (r_left == '0) begin
                        n_state = S_IDLE;
                    end else begin
                        o_ram.re    = 1'b1;
                        o_ram.raddr = ring_inc(r_addr);
                        n_addr      = ring_inc(r_addr);
                        n_left      = r_left - ADDR_W'(1);
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_front <= '0;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            r_front <= n_front;
            r_count <= n_count;
        end
    end

    // Dump walk registers
    always_ff @(posedge i_clk) begin
        r_addr <= n_addr;
        r_left <= n_left;
    end

    `BDQ_ASSERT(a_count_bound, i_clk, i_rst_n, r_count <= CNT_W'(DEPTH), "count above depth")
    `BDQ_ASSERT(a_load_ready, i_clk, i_rst_n, o_load |-> i_out_ready, "load into busy output")
    `BDQ_ASSERT(a_push_count, i_clk, i_rst_n, (o_ram.we && !o_ram.re) |=> (r_count == $past(r_count) + CNT_W'(1)), "push did not grow count")
    `BDQ_ASSERT(a_emit_read, i_clk, i_rst_n, (r_state == S_EMIT) |-> ($past(o_ram.re) || !$past(i_out_ready)), "emit without read")

endmodule

// ===== design/bounded_deque_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bounded_deque_top
// Bounded double-ended queue of signed 32-bit values held in a RAM ring.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_in_valid / o_in_stall / i_in_word) takes one command word:
//   push front, push back, pop front, pop back or dump. Output channel
//   (o_out_valid / i_out_stall / o_out_word) returns result words.
//   Pushes, empty pops and empty dumps give their result in the cycle after
//   acceptance, and the block takes another command in the next cycle: one
//   command a cycle while the receiver does not stall. A pop reads the RAM
//   ring (registered read) and emits the element from the emit state. A dump
//   of N elements reads one RAM entry a cycle while the receiver does not
//   stall; the final word carries last. Full pushes are dropped with status
//   full. Every word from one command is loaded before the next is accepted.
//   Reset empties the queue (front index and count to zero); the RAM is not
//   cleared, as only occupied entries are ever read.
//   When the receiver stalls, the held result word stays put, the dump walk
//   pauses, and o_in_stall rises until the output register can take a word.
// ----------------------------------------------------------------------------
module bounded_deque_top (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  bdq_pkg::t_in_word  i_in_word,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output bdq_pkg::t_out_word o_out_word
);
    import bdq_pkg::*;

    t_ram_req          ram_req;
    logic [DATA_W-1:0] ram_rdata;
    logic              out_ready;
    logic              out_load;
    t_out_word         out_word;

    // Queue controller
    bdq_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in_word   (i_in_word),
        .o_in_stall  (o_in_stall),
        .i_out_ready (out_ready),
        .o_load      (out_load),
        .o_word      (out_word),
        .o_ram       (ram_req),
        .i_rdata     (ram_rdata)
    );

    // Element store
    bdq_ram #(
        .W (DATA_W),
        .D (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_req.we),
        .i_waddr (ram_req.waddr),
        .i_wdata (ram_req.wdata),
        .i_re    (ram_req.re),
        .i_raddr (ram_req.raddr),
        .o_rdata (ram_rdata)
    );

    // Result register
    bdq_obuf u_obuf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (out_load),
        .i_word  (out_word),
        .o_ready (out_ready),
        .o_valid (o_out_valid),
        .i_stall (i_out_stall),
        .o_word  (o_out_word)
    );

endmodule

// ===== test/bounded_deque_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bounded_deque_checker
// Watches both channels of the deque, keeps its own copy of the ring, works
// out the result words each accepted command must give, and compares every
// delivered word against the oldest one still due.
// ----------------------------------------------------------------------------
module bounded_deque_checker (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  logic               i_in_stall,
    input  bdq_pkg::t_in_word  i_in_word,
    input  logic               i_out_valid,
    input  logic               i_out_stall,
    input  bdq_pkg::t_out_word i_out_word,
    output int                 o_fail_count,
    output int                 o_pending,
    output int                 o_cmd_count,
    output int                 o_word_count,
    output int                 o_dump_count,
    output int                 o_full_count,
    output int                 o_empty_count
);
    import bdq_pkg::*;

    // Shadow deque: ring contents, front position and fill level
    logic signed [DATA_W-1:0] ring_mem [DEPTH];
    logic [ADDR_W-1:0]        ring_head = '0;
    logic [CNT_W-1:0]         ring_fill = '0;

    // Result words still owed by the block, oldest first
    t_out_word due_words [$];

    int fails   = 0;
    int cmds    = 0;
    int words   = 0;
    int dumps   = 0;
    int fulls   = 0;
    int empties = 0;

    // Ring position a given distance from the front
    function automatic logic [ADDR_W-1:0] slot(input int off);
        return ADDR_W'((int'(ring_head) + off) % DEPTH);
    endfunction

    function automatic t_out_word make_word(
        input logic signed [DATA_W-1:0] v,
        input t_status                  st,
        input logic                     lst
    );
        t_out_word w;
        w.value_res = v;
        w.status    = st;
        w.last      = lst;
        return w;
    endfunction

    // Advance the shadow deque by one command and queue the words it owes
    task automatic apply_command(input t_in_word cmd);
        int i;
        case (cmd.operation)
            OP_PUSH_FRONT, OP_PUSH_BACK: begin
                if (ring_fill == CNT_W'(DEPTH)) begin
                    // drop the value, state untouched
                    due_words.push_back(make_word('0, ST_FULL, 1'b1));
                    fulls++;
                end else begin
                    if (cmd.operation == OP_PUSH_FRONT) begin
                        ring_head = slot(DEPTH - 1);
                        ring_mem[ring_head] = cmd.value;
                    end else begin
                        ring_mem[slot(int'(ring_fill))] = cmd.value;
                    end
                    ring_fill = ring_fill + 1'b1;
                    due_words.push_back(make_word('0, ST_ACCEPTED, 1'b1));
                end
            end
            OP_POP_FRONT, OP_POP_BACK: begin
                if (ring_fill == '0) begin
                    due_words.push_back(make_word('0, ST_EMPTY, 1'b1));
                    empties++;
                end else begin
                    if (cmd.operation == OP_POP_FRONT) begin
                        due_words.push_back(make_word(ring_mem[ring_head], ST_ELEMENT, 1'b1));
                        ring_head = slot(1);
                    end else begin
                        due_words.push_back(
                            make_word(ring_mem[slot(int'(ring_fill) - 1)], ST_ELEMENT, 1'b1));
                    end
                    ring_fill = ring_fill - 1'b1;
                end
            end
            OP_DUMP: begin
                dumps++;
                if (ring_fill == '0) begin
                    due_words.push_back(make_word('0, ST_EMPTY, 1'b1));
                    empties++;
                end else begin
                    // walk front to back, flag the final element
                    for (i = 0; i < int'(ring_fill); i++) begin
                        due_words.push_back(make_word(ring_mem[slot(i)], ST_ELEMENT,
                                                      i == int'(ring_fill) - 1));
                    end
                end
            end
            default: begin
                // unused codes leave the deque alone and owe nothing
            end
        endcase
    endtask

    // Compare one delivered word with the oldest one due
    task automatic check_word(input t_out_word got);
        t_out_word want;
        if (due_words.size() == 0) begin
            $error("unexpected result word: value_res %0d status %0d last %0d",
                   got.value_res, got.status, got.last);
            fails++;
        end else begin
            want = due_words.pop_front();
            if (got.value_res !== want.value_res) begin
                $error("value_res mismatch: expected %0d, actual %0d",
                       want.value_res, got.value_res);
                fails++;
            end
            if (got.status !== want.status) begin
                $error("status mismatch: expected %0d, actual %0d", want.status, got.status);
                fails++;
            end
            if (got.last !== want.last) begin
                $error("last mismatch: expected %0d, actual %0d", want.last, got.last);
                fails++;
            end
        end
    endtask

    // Sample both channels; retire output words before queueing new ones
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            ring_head = '0;
            ring_fill = '0;
            due_words.delete();
        end else begin
            if (i_out_valid && !i_out_stall) begin
                check_word(i_out_word);
                words++;
            end
            if (i_in_valid && !i_in_stall) begin
                apply_command(i_in_word);
                cmds++;
            end
        end
        o_fail_count  <= fails;
        o_pending     <= due_words.size();
        o_cmd_count   <= cmds;
        o_word_count  <= words;
        o_dump_count  <= dumps;
        o_full_count  <= fulls;
        o_empty_count <= empties;
    end

endmodule

// ===== test/tb_bounded_deque_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_bounded_deque_top
// Drives the deque with a directed opening (empty replies, value extremes,
// unused codes, overflow of a full ring) and then random command mixes that
// swing between filling and draining, with input gaps and output stalls.
// The checker beside the block does all prediction and comparison.
// ----------------------------------------------------------------------------
module tb_bounded_deque_top;
    import bdq_pkg::*;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int RAND_CMDS    = 190;
    localparam int QUIET_CMDS   = 40;
    localparam int LONG_HOLD    = 80;
    localparam int LONG_HOLD_AT = 70;
    localparam int DRAIN_CYCLES = 24;

    localparam logic signed [DATA_W-1:0] VAL_MIN = {1'b1, {(DATA_W-1){1'b0}}};
    localparam logic signed [DATA_W-1:0] VAL_MAX = {1'b0, {(DATA_W-1){1'b1}}};

    typedef enum int {
        MIX_FILL,
        MIX_DRAIN,
        MIX_BALANCED
    } t_mix;

    logic      i_clk       = 1'b0;
    logic      i_rst_n     = 1'b0;
    logic      i_in_valid  = 1'b0;
    t_in_word  i_in_word   = '0;
    logic      i_out_stall = 1'b0;
    logic      o_in_stall;
    logic      o_out_valid;
    t_out_word o_out_word;

    int fail_count;
    int pending;
    int cmd_count;
    int word_count;
    int dump_count;
    int full_count;
    int empty_count;

    bit quiet     = 1'b0;
    bit hold_done = 1'b0;
    int hold_left  = 0;
    int stall_left = 0;
    int free_left  = 0;
    int cycles     = 0;

    bounded_deque_top uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_word   (i_in_word),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_word  (o_out_word)
    );

    bounded_deque_checker u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .i_in_stall    (o_in_stall),
        .i_in_word     (i_in_word),
        .i_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .i_out_word    (o_out_word),
        .o_fail_count  (fail_count),
        .o_pending     (pending),
        .o_cmd_count   (cmd_count),
        .o_word_count  (word_count),
        .o_dump_count  (dump_count),
        .o_full_count  (full_count),
        .o_empty_count (empty_count)
    );

    always #1 i_clk = ~i_clk;

    // Receiver back-pressure: random bursts and one long hold-off
    always @(negedge i_clk) begin
        if (hold_left != 0) begin
            hold_left--;
            i_out_stall <= 1'b1;
        end else if (!hold_done && cmd_count >= LONG_HOLD_AT) begin
            // hold off long enough for the deque to back up onto its input
            hold_done = 1'b1;
            hold_left = LONG_HOLD - 1;
            i_out_stall <= 1'b1;
        end else if (!i_rst_n || quiet) begin
            stall_left = 0;
            i_out_stall <= 1'b0;
        end else if (stall_left != 0) begin
            stall_left--;
            i_out_stall <= 1'b1;
        end else if (free_left != 0) begin
            free_left--;
            i_out_stall <= 1'b0;
        end else if ($urandom_range(2) == 0) begin
            stall_left = $urandom_range(4, 1) - 1;
            i_out_stall <= 1'b1;
        end else begin
            free_left = ($urandom_range(5) == 0) ? $urandom_range(40, 20) : $urandom_range(8);
            i_out_stall <= 1'b0;
        end
    end

    // Bound the run
    initial begin
        while (cycles < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("Timed out after %0d cycles with %0d words outstanding", cycles, pending);
        $display("*** FAILED ***");
        $finish;
    end

    function automatic logic signed [DATA_W-1:0] pick_value();
        case ($urandom_range(11))
            0:       return VAL_MIN;
            1:       return VAL_MAX;
            2:       return '0;
            3:       return '1;
            default: return $urandom();
        endcase
    endfunction

    // Pick an operation, weighted towards filling or draining by the mix
    function automatic logic [2:0] pick_op(input t_mix mix);
        int r;
        int push_lim;
        int pop_lim;
        r = $urandom_range(99);
        case (mix)
            MIX_FILL:  begin push_lim = 65; pop_lim = 85; end
            MIX_DRAIN: begin push_lim = 25; pop_lim = 82; end
            default:   begin push_lim = 45; pop_lim = 85; end
        endcase
        if (r < push_lim) begin
            return ($urandom_range(1) == 0) ? OP_PUSH_FRONT : OP_PUSH_BACK;
        end else if (r < pop_lim) begin
            return ($urandom_range(1) == 0) ? OP_POP_FRONT : OP_POP_BACK;
        end else if (r < 96) begin
            return OP_DUMP;
        end
        return 3'($urandom_range(7, 5));
    endfunction

    // Offer one command word, with an optional idle burst first; hold it until taken
    task automatic offer_command(input logic [2:0] op, input logic signed [DATA_W-1:0] val);
        int       gap;
        t_in_word w;
        gap = (!quiet && $urandom_range(4) == 0) ? $urandom_range(4, 1) : 0;
        w.operation = op;
        w.value     = val;
        if (gap != 0) begin
            @(negedge i_clk);
            i_in_valid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        i_in_valid <= 1'b1;
        i_in_word  <= w;
        do @(posedge i_clk); while (o_in_stall);
    endtask

    // Stop offering and wait for every owed word to arrive
    task automatic wait_drained();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
    endtask

    initial begin
        int         done;
        int         seg_left;
        t_mix       mix;
        logic [2:0] op;

        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // empty-queue replies from both pops and a dump
        offer_command(OP_POP_FRONT, 32'sd5);
        offer_command(OP_POP_BACK, -32'sd5);
        offer_command(OP_DUMP, '1);

        // value extremes; the first front push wraps the front index
        offer_command(OP_PUSH_FRONT, VAL_MIN);
        offer_command(OP_PUSH_BACK, VAL_MAX);
        offer_command(OP_PUSH_FRONT, '1);
        offer_command(OP_DUMP, '0);
        offer_command(OP_POP_BACK, '0);
        offer_command(OP_POP_FRONT, '0);

        // unused codes: no effect, no words
        for (int c = 5; c <= 7; c++) begin
            offer_command(3'(c), pick_value());
        end

        // fill from both ends, push into the full ring, then dump it whole
        for (int k = 0; k < DEPTH - 1; k++) begin
            offer_command(k[0] ? OP_PUSH_BACK : OP_PUSH_FRONT, pick_value());
        end
        offer_command(OP_PUSH_FRONT, 32'sd1);
        offer_command(OP_PUSH_BACK, 32'sd2);
        offer_command(OP_DUMP, '0);
        wait_drained();

        // random mixes in segments; unused codes do not count
        done     = 0;
        seg_left = 0;
        mix      = MIX_BALANCED;
        while (done < RAND_CMDS) begin
            if (seg_left == 0) begin
                mix      = t_mix'($urandom_range(2));
                seg_left = $urandom_range(40, 15);
            end
            if (done >= RAND_CMDS - QUIET_CMDS) begin
                quiet = 1'b1;
            end
            op = pick_op(mix);
            offer_command(op, pick_value());
            if (op <= OP_DUMP) begin
                done++;
                seg_left--;
            end
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Run covered %0d commands and %0d result words, including %0d dumps,",
                 cmd_count, word_count, dump_count);
        $display("%0d pushes dropped on a full ring and %0d empty replies; one %0d-cycle hold-off.",
                 full_count, empty_count, LONG_HOLD);
        if (fail_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+design
design/bdq_pkg.sv
design/bdq_ram.sv
design/bdq_obuf.sv
design/bdq_ctrl.sv
design/bounded_deque_top.sv
test/bounded_deque_checker.sv
test/tb_bounded_deque_top.sv
